FILE: hdl/jpp_pkg.sv
// Package for the jump phase profile generator: field widths, phase codes,
// gain constants, register indexes and reset values, state type, curve entry function.
// No dependencies.
`timescale 1ns / 1ps

package jpp_pkg;

  localparam int HEIGHT_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int CURVE_W   = 17;
  localparam int CNT_W     = 5;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SQUAT  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_THRUST = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FLIGHT = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LAND   = 3'd4;

  // Gains, Q0.16
  localparam logic [GAIN_W-1:0] KP_LOW  = 16'd9830;
  localparam logic [GAIN_W-1:0] KP_MID  = 16'd13107;
  localparam logic [GAIN_W-1:0] KP_HIGH = 16'd19661;
  localparam logic [GAIN_W-1:0] KD_LOW  = 16'd6554;
  localparam logic [GAIN_W-1:0] KD_HIGH = 16'd13107;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_STAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SQUAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_EXTEND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_AIR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUAT_MS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRUST_MS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_MS        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_MS    = 3'd7;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_HEIGHT_STAND  = 16'd6656;
  localparam logic [CFG_W-1:0] RST_HEIGHT_SQUAT  = 16'd3584;
  localparam logic [CFG_W-1:0] RST_HEIGHT_EXTEND = 16'd8448;
  localparam logic [CFG_W-1:0] RST_HEIGHT_AIR    = 16'd5120;
  localparam logic [CFG_W-1:0] RST_SQUAT_MS      = 16'd800;
  localparam logic [CFG_W-1:0] RST_THRUST_MS     = 16'd80;
  localparam logic [CFG_W-1:0] RST_AIR_MS        = 16'd300;
  localparam logic [CFG_W-1:0] RST_LANDING_MS    = 16'd500;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_ROM    = 7'b0001000,
    ST_MUL0   = 7'b0010000,
    ST_MUL1   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } seq_state_t;

  // One S-curve entry: round(65536 * sin^2(pi*u / 2^(bits+1))), sin in Q30 by Taylor series.
  function automatic logic [CURVE_W-1:0] curve_entry(input int u, input int bits);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] sq;
    y    = (PI_Q30 * 64'(u)) >> (bits + 1);
    y2   = (y * y) >> 30;
    term = y;
    pos  = y;
    neg  = 64'd0;
    term = ((term * y2) >> 30) / 64'd6;
    neg  = neg + term;
    term = ((term * y2) >> 30) / 64'd20;
    pos  = pos + term;
    term = ((term * y2) >> 30) / 64'd42;
    neg  = neg + term;
    term = ((term * y2) >> 30) / 64'd72;
    pos  = pos + term;
    term = ((term * y2) >> 30) / 64'd110;
    neg  = neg + term;
    s = (pos > neg) ? (pos - neg) : 64'd0;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    sq = (s * s + (64'd1 << 43)) >> 44;
    return sq[CURVE_W-1:0];
  endfunction

endpackage

FILE: hdl/jpp_if.sv
// Valid/ready channel interfaces for the jump phase profile generator:
// the input item channel and the result item channel. Depends on jpp_pkg.
`timescale 1ns / 1ps

interface jpp_in_if;
  import jpp_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output command, output now_ms, input ready);
  modport sink   (input valid, input command, input now_ms, output ready);
endinterface

interface jpp_out_if;
  import jpp_pkg::*;

  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] target_height;
  logic [GAIN_W-1:0]   stiffness;
  logic [GAIN_W-1:0]   damping;
  logic [PHASE_W-1:0]  phase;

  modport source (output valid, output target_height, output stiffness, output damping,
                  output phase, input ready);
  modport sink   (input valid, input target_height, input stiffness, input damping,
                  input phase, output ready);
endinterface

FILE: hdl/jump_phase_profile_generator.sv
// Top level of the jump phase profile generator: phase sequencer, serial divider,
// shared multiplier and S-curve ROM. Depends on jpp_pkg and jpp_if.
`timescale 1ns / 1ps

// How to use:
//   in_item  (valid/ready): command 0 = update tick, 1 = jump trigger; now_ms is the
//            free-running millisecond time. A trigger starts the squat only from idle
//            and gives no result item.
//   out_item (valid/ready): one result item per update: target height (Q8.8), stiffness
//            and damping (Q0.16) and the phase after the update.
//   cfg_we/cfg_index/cfg_data: write the eight heights and durations while idle.
// Steps, accept to result valid:
//   trigger                         : evaluate, back to idle, no result
//   update at or past phase end     : evaluate, finish
//   S-curve phases (squat/air/land) : evaluate, divide, ROM read, multiply twice, finish
//   linear thrust phase             : evaluate, multiply twice, divide, finish
// The serial divider (one quotient bit a cycle) and the single multiplier, used twice
// per blended item, do the blend arithmetic; one item is worked on at a time.
// Reset clears the phase to idle, the phase start time to zero and loads the register
// defaults; no clearing pass is needed. The finished result sits in an output register,
// so the next item is taken while it waits; if the receiver stalls with a result still
// held, the following result waits in the sequencer and input ready stays low.
module jump_phase_profile_generator #(
  parameter int CURVE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [jpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jpp_pkg::CFG_W-1:0]     cfg_data,
  jpp_in_if.sink                        in_item,
  jpp_out_if.source                     out_item
);
  import jpp_pkg::*;

  localparam int CURVE_SIZE = 1 << CURVE_TABLE_BITS;

  typedef logic [CURVE_W-1:0] curve_rom_t [CURVE_SIZE];

  function automatic curve_rom_t build_curve();
    curve_rom_t rom;
    for (int u = 0; u < CURVE_SIZE; u++) begin
      rom[u] = curve_entry(u, CURVE_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE = build_curve();

  // Configuration registers
  logic [CFG_W-1:0] height_stand, height_squat, height_extend, height_air;
  logic [CFG_W-1:0] squat_ms, thrust_ms, air_ms, landing_ms;

  // Control state
  seq_state_t         state;
  logic [PHASE_W-1:0] phase_reg;
  logic [TIME_W-1:0]  phase_start;
  logic [CNT_W-1:0]   cnt;
  logic               out_valid;

  // Held item and working registers
  logic                command;
  logic [TIME_W-1:0]   now_ms;
  logic                lin;
  logic [HEIGHT_W-1:0] h_start, h_end, h_res;
  logic [DUR_W-1:0]    dur, t;
  logic [GAIN_W-1:0]   kp, kd;
  logic [PHASE_W-1:0]  ph_out;
  logic [31:0]         acc;
  logic [DUR_W-1:0]    rem;
  logic [15:0]         low;
  logic [15:0]         q;
  logic [CURVE_W-1:0]  rom_q;

  // Output register
  logic [HEIGHT_W-1:0] out_height;
  logic [GAIN_W-1:0]   out_kp, out_kd;
  logic [PHASE_W-1:0]  out_phase;

  // Phase decode for the held item
  logic [TIME_W-1:0]   elapsed;
  logic [HEIGHT_W-1:0] sel_start, sel_end;
  logic [DUR_W-1:0]    sel_dur;
  logic [GAIN_W-1:0]   sel_kp, sel_kd;
  logic [PHASE_W-1:0]  sel_next;
  logic                sel_active, sel_lin, sel_restart, sel_done;

  // Shared multiplier and divider step
  logic [HEIGHT_W-1:0] mul_a;
  logic [CURVE_W-1:0]  mul_b;
  logic [32:0]         prod;
  logic [31:0]         acc_sum;
  logic [16:0]         shifted;
  logic                ge;
  logic [15:0]         q_next;
  logic                out_load;

  assign in_item.ready = (state == ST_IDLE);
  assign out_load      = (state == ST_FINISH) && (!out_valid || out_item.ready);

  assign out_item.valid         = out_valid;
  assign out_item.target_height = out_height;
  assign out_item.stiffness     = out_kp;
  assign out_item.damping       = out_kd;
  assign out_item.phase         = out_phase;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      height_stand  <= RST_HEIGHT_STAND;
      height_squat  <= RST_HEIGHT_SQUAT;
      height_extend <= RST_HEIGHT_EXTEND;
      height_air    <= RST_HEIGHT_AIR;
      squat_ms      <= RST_SQUAT_MS;
      thrust_ms     <= RST_THRUST_MS;
      air_ms        <= RST_AIR_MS;
      landing_ms    <= RST_LANDING_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT_STAND:  height_stand  <= cfg_data;
        CFG_HEIGHT_SQUAT:  height_squat  <= cfg_data;
        CFG_HEIGHT_EXTEND: height_extend <= cfg_data;
        CFG_HEIGHT_AIR:    height_air    <= cfg_data;
        CFG_SQUAT_MS:      squat_ms      <= cfg_data;
        CFG_THRUST_MS:     thrust_ms     <= cfg_data;
        CFG_AIR_MS:        air_ms        <= cfg_data;
        CFG_LANDING_MS:    landing_ms    <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Elapsed time wraps modulo 2^32; pick the blend endpoints, duration and gains.
  always_comb begin
    elapsed     = now_ms - phase_start;
    sel_start   = height_stand;
    sel_end     = height_stand;
    sel_dur     = '0;
    sel_kp      = KP_MID;
    sel_kd      = KD_LOW;
    sel_next    = PH_IDLE;
    sel_active  = 1'b0;
    sel_lin     = 1'b0;
    sel_restart = 1'b0;
    case (phase_reg)
      PH_SQUAT: begin
        sel_start = height_stand;  sel_end = height_squat;  sel_dur = squat_ms;
        sel_kp = KP_MID;  sel_kd = KD_HIGH; sel_next = PH_THRUST;
        sel_active = 1'b1; sel_restart = 1'b1;
      end
      PH_THRUST: begin
        sel_start = height_squat;  sel_end = height_extend; sel_dur = thrust_ms;
        sel_kp = KP_HIGH; sel_kd = KD_LOW;  sel_next = PH_FLIGHT;
        sel_active = 1'b1; sel_restart = 1'b1; sel_lin = 1'b1;
      end
      PH_FLIGHT: begin
        sel_start = height_extend; sel_end = height_air;    sel_dur = air_ms;
        sel_kp = KP_MID;  sel_kd = KD_HIGH; sel_next = PH_LAND;
        sel_active = 1'b1; sel_restart = 1'b1;
      end
      PH_LAND: begin
        // Leaving landing keeps the phase start time.
        sel_start = height_air;    sel_end = height_stand;  sel_dur = landing_ms;
        sel_kp = KP_LOW;  sel_kd = KD_HIGH; sel_next = PH_IDLE;
        sel_active = 1'b1;
      end
      default: ;
    endcase
    sel_done = (elapsed >= {{(TIME_W-DUR_W){1'b0}}, sel_dur});
  end

  // Shared multiplier: first pass weights the start height, second the end height.
  always_comb begin
    mul_a = (state == ST_MUL1) ? h_end : h_start;
    if (lin) begin
      mul_b = (state == ST_MUL1) ? {1'b0, t} : {1'b0, dur - t};
    end else begin
      mul_b = (state == ST_MUL1) ? rom_q : (CURVE_W'(1 << 16) - rom_q);
    end
    prod    = {{CURVE_W{1'b0}}, mul_a} * {{HEIGHT_W{1'b0}}, mul_b};
    acc_sum = acc + prod[31:0];
  end

  // Restoring divider step: remainder stays below the duration.
  always_comb begin
    shifted = {rem, low[15]};
    ge      = (shifted >= {1'b0, dur});
    q_next  = {q[14:0], ge};
  end

  // Registered ROM read
  always_ff @(posedge clk) begin
    rom_q <= CURVE[q[CURVE_TABLE_BITS-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase_reg   <= PH_IDLE;
      phase_start <= '0;
      cnt         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_item.valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (command) begin
            // Trigger: start the squat only from idle, no result.
            if (phase_reg == PH_IDLE) begin
              phase_reg   <= PH_SQUAT;
              phase_start <= now_ms;
            end
            state <= ST_IDLE;
          end else if (!sel_active) begin
            phase_reg <= PH_IDLE;
            state     <= ST_FINISH;
          end else if (sel_done) begin
            phase_reg <= sel_next;
            if (sel_restart) begin
              phase_start <= now_ms;
            end
            state <= ST_FINISH;
          end else if (sel_lin) begin
            state <= ST_MUL0;
          end else begin
            cnt   <= CNT_W'(CURVE_TABLE_BITS - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= lin ? ST_FINISH : ST_ROM;
          end
        end
        ST_ROM:  state <= ST_MUL0;
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: begin
          if (lin) begin
            cnt   <= CNT_W'(15);
            state <= ST_DIV;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        command <= in_item.command;
        now_ms  <= in_item.now_ms;
      end
      ST_EVAL: begin
        lin     <= sel_lin;
        h_start <= sel_start;
        h_end   <= sel_end;
        dur     <= sel_dur;
        t       <= elapsed[DUR_W-1:0];
        kp      <= sel_kp;
        kd      <= sel_kd;
        // Hold the end height; the blend overwrites it when the phase continues.
        h_res   <= sel_end;
        ph_out  <= (sel_active && sel_done) ? sel_next :
                   (sel_active ? phase_reg : PH_IDLE);
        acc     <= sel_lin ? {17'd0, sel_dur[DUR_W-1:1]} : 32'h0000_8000;
        rem     <= elapsed[DUR_W-1:0];
        low     <= '0;
        q       <= '0;
      end
      ST_DIV: begin
        rem  <= ge ? DUR_W'(shifted - {1'b0, dur}) : shifted[DUR_W-1:0];
        low  <= {low[14:0], 1'b0};
        q    <= q_next;
        if (cnt == '0 && lin) begin
          h_res <= q_next;
        end
      end
      ST_MUL0: acc <= acc_sum;
      ST_MUL1: begin
        acc <= acc_sum;
        if (lin) begin
          // Numerator top half starts the remainder; it is below the duration.
          rem <= acc_sum[31:16];
          low <= acc_sum[15:0];
          q   <= '0;
        end else begin
          h_res <= acc_sum[31:16];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_height <= h_res;
      out_kp     <= kp;
      out_kd     <= kd;
      out_phase  <= ph_out;
    end
  end

  // Checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_reg <= PH_LAND)
    else $error("phase register out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dur))
    else $error("divider remainder not below duration");

  a_trigger: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && command && phase_reg == PH_IDLE) |=> (phase_reg == PH_SQUAT))
    else $error("trigger from idle did not start squat");

  a_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_item.valid && out_item.phase == $past(ph_out)))
    else $error("finished result not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && command) |=> (state == ST_IDLE && !$past(out_load)))
    else $error("trigger produced a result");

endmodule
